// ===== src/elf_load_segment_checker_assert.svh =====
`ifndef ELF_LOAD_SEGMENT_CHECKER_ASSERT_SVH
`define ELF_LOAD_SEGMENT_CHECKER_ASSERT_SVH
// implication checked on every clock unless reset is low
`define ELSC_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication
`define ELSC_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ===== src/elsc_pkg.sv =====
package elsc_pkg;
  localparam int unsigned MaxSegments = 8;
  localparam int unsigned MaxHeaders = 16;
  localparam int unsigned PageBits = 12;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FORMAT = 3'd1;
  localparam logic [2:0] ST_UNSUP = 3'd2;
  localparam logic [2:0] ST_BOUNDS = 3'd3;
  localparam logic [2:0] ST_OVERLAP = 3'd4;

  localparam logic [1:0] CFG_WIN_BASE = 2'd0;
  localparam logic [1:0] CFG_WIN_LIMIT = 2'd1;
  localparam logic [1:0] CFG_STACK_FLOOR = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_HEADER = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] file_size;
    logic [63:0] entry_addr;
    logic [31:0] seg_type;
    logic [63:0] seg_offset;
    logic [63:0] seg_vaddr;
    logic [63:0] seg_file_bytes;
    logic [63:0] seg_mem_bytes;
    logic        last_header;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  error_index;
    logic        final_result;
    logic [3:0]  seg_count;
    logic [31:0] img_low;
    logic [32:0] img_high;
    logic [32:0] brk_end;
    logic [31:0] seg_map_base;
    logic [20:0] seg_pages;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic        is_start;
    logic        is_load;
    logic        last;
    logic [2:0]  pre_code;
    logic [31:0] file_size;
    logic [31:0] entry;
    logic        entry_wide;
    logic [31:0] offset;
    logic [31:0] file_bytes;
    logic [32:0] vaddr;
    logic [32:0] seg_end;
  } work_t;
endpackage

// ===== src/elsc_front.sv =====
module elsc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  elsc_pkg::in_item_t in_data,
  output logic               w_valid,
  input  logic               w_stall,
  output elsc_pkg::work_t    w_data
);
  import elsc_pkg::*;

  localparam int unsigned Depth = 2;

  work_t     q_r [Depth];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  work_t     wk;
  logic      push, pop;
  logic      wide;

  always_comb begin
    wide = (in_data.seg_offset[63:32] != '0) || (in_data.seg_file_bytes[63:32] != '0) ||
           (in_data.seg_mem_bytes[63:32] != '0) || (in_data.seg_vaddr[63:32] != '0);
    wk = '0;
    wk.is_start = (in_data.req_type == REQ_START);
    wk.is_load = (in_data.seg_type == 32'd1) && (in_data.seg_mem_bytes != '0);
    wk.last = in_data.last_header;
    wk.file_size = in_data.file_size;
    wk.entry = in_data.entry_addr[31:0];
    wk.entry_wide = (in_data.entry_addr[63:32] != '0);
    wk.offset = in_data.seg_offset[31:0];
    wk.file_bytes = in_data.seg_file_bytes[31:0];
    wk.vaddr = {1'b0, in_data.seg_vaddr[31:0]};
    wk.seg_end = {1'b0, in_data.seg_vaddr[31:0]} + {1'b0, in_data.seg_mem_bytes[31:0]};
    if (in_data.seg_file_bytes > in_data.seg_mem_bytes) begin
      wk.pre_code = ST_FORMAT;
    end else if (wide) begin
      wk.pre_code = ST_BOUNDS;
    end else begin
      wk.pre_code = ST_OK;
    end
  end

  assign in_stall = (cnt_r == 2'(Depth));
  assign push = in_valid && !in_stall;
  assign w_valid = (cnt_r != '0);
  assign pop = w_valid && !w_stall;
  assign w_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      q_r[wp_r] <= wk;
    end
  end
endmodule

// ===== src/elsc_back.sv =====
module elsc_back #(
  parameter int unsigned MAX_SEGMENTS = elsc_pkg::MaxSegments,
  parameter int unsigned MAX_HEADERS = elsc_pkg::MaxHeaders,
  parameter int unsigned PAGE_BITS = elsc_pkg::PageBits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                w_valid,
  output logic                w_stall,
  input  elsc_pkg::work_t     w_data,
  input  logic [31:0]         win_base,
  input  logic [32:0]         win_limit,
  input  logic [31:0]         stack_floor,
  output logic                out_valid,
  input  logic                out_stall,
  output elsc_pkg::out_item_t out_data
);
  import elsc_pkg::*;

  localparam int unsigned SegIdxW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned PosW = $clog2(MAX_HEADERS + 1);
  localparam int unsigned PgW = 33 - PAGE_BITS;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_COMMIT, S_OUT} state_t;

  state_t state_r;
  work_t  w_r;
  logic [PgW-1:0]  pb_r [MAX_SEGMENTS];
  logic [PgW-1:0]  pe_r [MAX_SEGMENTS];
  logic [31:0]     sa_r [MAX_SEGMENTS];
  logic [32:0]     ea_r [MAX_SEGMENTS];
  logic [CntW-1:0] cnt_r;
  logic [PosW-1:0] pos_r;
  logic [31:0] low_r, held_entry_r, held_fs_r;
  logic [32:0] high_r, brk_r;
  logic [2:0]  sticky_r;
  logic [PosW-1:0] err_pos_r;
  logic        closed_r;
  logic [2:0]  code1_r;
  logic [32:0] mbase_r, mend_r;
  out_item_t   out_r;

  logic [32:0] pmask, mbase, mend, off_end;
  logic [2:0]  code1;
  logic        ovl, entry_hit;

  always_comb begin
    pmask = 33'((64'd1 << PAGE_BITS) - 64'd1);
    mbase = w_r.vaddr & ~pmask;
    mend = (w_r.seg_end + pmask) & ~pmask;
    off_end = {1'b0, w_r.offset} + {1'b0, w_r.file_bytes};
    if (32'(pos_r) >= MAX_HEADERS) begin
      code1 = ST_UNSUP;
    end else if (32'(cnt_r) >= MAX_SEGMENTS) begin
      code1 = ST_UNSUP;
    end else if (w_r.pre_code != ST_OK) begin
      code1 = w_r.pre_code;
    end else if (off_end > {1'b0, held_fs_r}) begin
      code1 = ST_FORMAT;
    end else if (w_r.vaddr[31:0] < win_base || w_r.seg_end <= w_r.vaddr ||
                 w_r.seg_end > win_limit || w_r.seg_end[32]) begin
      code1 = ST_BOUNDS;
    end else if (mend <= mbase || mend > win_limit) begin
      code1 = ST_BOUNDS;
    end else begin
      code1 = ST_OK;
    end
    ovl = 1'b0;
    entry_hit = 1'b0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (32'(i) < 32'(cnt_r)) begin
        if (mbase_r < {pe_r[i], PAGE_BITS'(0)} && mend_r > {pb_r[i], PAGE_BITS'(0)}) begin
          ovl = 1'b1;
        end
        if (held_entry_r >= sa_r[i] && {1'b0, held_entry_r} < ea_r[i]) begin
          entry_hit = 1'b1;
        end
      end
    end
  end

  assign w_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    logic [2:0] st;
    logic [PosW-1:0] ep;
    logic [CntW-1:0] cn;
    logic [31:0] lo;
    logic [32:0] hi, bk;
    logic [31:0] mb;
    logic [20:0] mp;
    logic fin;
    st = sticky_r; ep = err_pos_r; cn = cnt_r; lo = low_r; hi = high_r; bk = brk_r;
    mb = '0; mp = '0; fin = 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0; pos_r <= '0; low_r <= '0; high_r <= '0; brk_r <= '0;
      held_entry_r <= '0; held_fs_r <= '0; sticky_r <= ST_OK; err_pos_r <= '0;
      closed_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (w_valid) begin
            w_r <= w_data;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (w_r.is_start) begin
            st = w_r.entry_wide ? ST_BOUNDS : ST_OK;
            ep = '0; cn = '0; lo = '0; hi = '0; bk = '0;
            held_fs_r <= w_r.file_size;
            held_entry_r <= w_r.entry;
            pos_r <= '0;
            closed_r <= 1'b0;
            state_r <= S_OUT;
          end else if (closed_r) begin
            state_r <= S_OUT;
          end else begin
            code1_r <= code1;
            mbase_r <= mbase;
            mend_r <= mend;
            state_r <= S_COMMIT;
          end
          sticky_r <= st; err_pos_r <= ep; cnt_r <= cn; low_r <= lo; high_r <= hi; brk_r <= bk;
          out_r.status <= st;
          out_r.error_index <= (32'(ep) > 15) ? 4'd15 : 4'(ep);
          out_r.final_result <= 1'b0;
          out_r.seg_count <= 4'(cn);
          out_r.img_low <= lo;
          out_r.img_high <= hi;
          out_r.brk_end <= bk;
          out_r.seg_map_base <= '0;
          out_r.seg_pages <= '0;
        end
        S_COMMIT: begin
          if (32'(pos_r) < MAX_HEADERS) begin
            pos_r <= pos_r + 1'b1;
          end
          if (st == ST_OK && w_r.is_load) begin
            if (code1_r != ST_OK) begin
              st = code1_r; ep = pos_r;
            end else if (ovl) begin
              st = ST_OVERLAP; ep = pos_r;
            end else begin
              pb_r[cnt_r[SegIdxW-1:0]] <= mbase_r[32:PAGE_BITS];
              pe_r[cnt_r[SegIdxW-1:0]] <= mend_r[32:PAGE_BITS];
              sa_r[cnt_r[SegIdxW-1:0]] <= w_r.vaddr[31:0];
              ea_r[cnt_r[SegIdxW-1:0]] <= w_r.seg_end;
              cn = cnt_r + 1'b1;
              if (low_r == '0 || mbase_r[31:0] < low_r) lo = mbase_r[31:0];
              if (mend_r > high_r) hi = mend_r;
              if (mend_r > brk_r) bk = mend_r;
              mb = mbase_r[31:0];
              mp = 21'((mend_r - mbase_r) >> PAGE_BITS);
            end
          end else if (st == ST_OK && 32'(pos_r) >= MAX_HEADERS) begin
            st = ST_UNSUP; ep = pos_r;
          end
          if (w_r.last) begin
            fin = 1'b1;
            closed_r <= 1'b1;
            if (st == ST_OK) begin
              // new segment counts toward entry check too
              if (cn == '0) begin
                st = ST_UNSUP; ep = pos_r;
              end else if (!(entry_hit || (mp != '0 && held_entry_r >= w_r.vaddr[31:0] &&
                             {1'b0, held_entry_r} < w_r.seg_end))) begin
                st = ST_FORMAT; ep = pos_r;
              end else if (bk > {1'b0, stack_floor}) begin
                st = ST_BOUNDS; ep = pos_r;
              end
            end
          end
          sticky_r <= st; err_pos_r <= ep; cnt_r <= cn; low_r <= lo; high_r <= hi; brk_r <= bk;
          out_r.status <= st;
          out_r.error_index <= (32'(ep) > 15) ? 4'd15 : 4'(ep);
          out_r.final_result <= fin;
          out_r.seg_count <= 4'(cn);
          out_r.img_low <= lo;
          out_r.img_high <= hi;
          out_r.brk_end <= bk;
          out_r.seg_map_base <= mb;
          out_r.seg_pages <= mp;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/elf_load_segment_checker.sv =====
// channel | ports                         | accepted when
// input   | in_valid in_stall in_data     | in_valid && !in_stall
// result  | out_valid out_stall out_data  | out_valid && !out_stall
// config  | cfg_we cfg_index cfg_data     | cfg_we
// a header item passes through capture, scalar checks, table compare and update, and
// result in the back part; a start item or a header after the last one skips the table step
// out_stall holds the result; an item is registered in the queue before capture
// the two-entry queue lets the front take items while the back works, in_stall when full
// reset is synchronous; state, counters and config return to reset values, data registers are not reset
module elf_load_segment_checker #(
  parameter int unsigned MAX_SEGMENTS = elsc_pkg::MaxSegments,
  parameter int unsigned MAX_HEADERS = elsc_pkg::MaxHeaders,
  parameter int unsigned PAGE_BITS = elsc_pkg::PageBits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  elsc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output elsc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [32:0]         cfg_data
);
  import elsc_pkg::*;

  logic [31:0] base_r, floor_r;
  logic [32:0] limit_r;
  logic        w_valid, w_stall;
  work_t       w_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 32'd4194304;
      limit_r <= 33'd3221225472;
      floor_r <= 32'd3204448256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_BASE: base_r <= cfg_data[31:0];
        CFG_WIN_LIMIT: limit_r <= cfg_data;
        CFG_STACK_FLOOR: floor_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  elsc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .w_valid(w_valid), .w_stall(w_stall), .w_data(w_data)
  );

  elsc_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS), .MAX_HEADERS(MAX_HEADERS), .PAGE_BITS(PAGE_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .w_valid(w_valid), .w_stall(w_stall), .w_data(w_data),
    .win_base(base_r), .win_limit(limit_r), .stack_floor(floor_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule

// ===== src/elsc_checker.sv =====
`include "elf_load_segment_checker_assert.svh"
module elsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input elsc_pkg::out_item_t out_data
);
  import elsc_pkg::*;

  `ELSC_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid, "input dropped")
  `ELSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result dropped while stalled")
  `ELSC_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_data.status <= ST_OVERLAP, "bad status code")
  `ELSC_ASSERT_IMP(a_ok_index, clk, rst_n, out_valid && out_data.status == ST_OK, out_data.error_index == 4'd0, "index set without error")
  `ELSC_ASSERT_IMP(a_pages_base, clk, rst_n, out_valid && out_data.seg_pages == '0, out_data.seg_map_base == '0, "base without pages")
endmodule

bind elf_load_segment_checker elsc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import elsc_pkg::*;

  class header_scoreboard;
    logic [31:0] win_base;
    logic [32:0] win_limit;
    logic [31:0] stack_limit;
    logic [19:0] pg_base[MaxSegments];
    logic [20:0] pg_end[MaxSegments];
    logic [31:0] va_start[MaxSegments];
    logic [32:0] va_end[MaxSegments];
    int unsigned n_seg, hdr_pos, err_pos;
    logic [31:0] low_mark, entry, fsize;
    logic [32:0] high_mark, brk;
    logic [2:0] status;
    bit closed;
    out_item_t pending[$];
    int errors;

    function new();
      win_base = 32'd4194304;
      win_limit = 33'd3221225472;
      stack_limit = 32'd3204448256;
      entry = 0;
      fsize = 0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      n_seg = 0;
      hdr_pos = 0;
      err_pos = 0;
      low_mark = 0;
      high_mark = 0;
      brk = 0;
      status = ST_OK;
      closed = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [32:0] v);
      case (idx)
        CFG_WIN_BASE: win_base = v[31:0];
        CFG_WIN_LIMIT: win_limit = v;
        CFG_STACK_FLOOR: stack_limit = v[31:0];
        default: ;
      endcase
    endfunction

    function void flag(logic [2:0] code, int unsigned pos);
      if (status == ST_OK) begin
        status = code;
        err_pos = pos;
      end
    endfunction

    function logic [2:0] check_seg(in_item_t d, output logic [32:0] b, output logic [32:0] e);
      logic [64:0] send, mb, me;
      logic [32:0] pm;
      pm = (33'd1 << PageBits) - 33'd1;
      b = 0;
      e = 0;
      if (n_seg >= MaxSegments) return ST_UNSUP;
      if (d.seg_file_bytes > d.seg_mem_bytes) return ST_FORMAT;
      if (d.seg_offset[63:32] != 0 || d.seg_file_bytes[63:32] != 0 ||
          d.seg_mem_bytes[63:32] != 0 || d.seg_vaddr[63:32] != 0) return ST_BOUNDS;
      if (65'(d.seg_offset) + 65'(d.seg_file_bytes) > 65'(fsize)) return ST_FORMAT;
      send = 65'(d.seg_vaddr) + 65'(d.seg_mem_bytes);
      if (d.seg_vaddr < 64'(win_base) || send <= 65'(d.seg_vaddr) || send > 65'(win_limit))
        return ST_BOUNDS;
      if (send > 65'hFFFFFFFF) return ST_BOUNDS;
      mb = 65'(d.seg_vaddr) & ~65'(pm);
      me = (send + 65'(pm)) & ~65'(pm);
      if (me <= mb) return ST_BOUNDS;
      if (me > 65'(win_limit)) return ST_BOUNDS;
      for (int i = 0; i < n_seg; i++)
        if (mb < (65'(pg_end[i]) << PageBits) && me > (65'(pg_base[i]) << PageBits))
          return ST_OVERLAP;
      b = mb[32:0];
      e = me[32:0];
      return ST_OK;
    endfunction

    function void note_item(in_item_t d);
      out_item_t r;
      logic [32:0] b, e;
      logic [2:0] code;
      int unsigned pos;
      bit hit;
      r = '0;
      if (d.req_type == REQ_START) begin
        clear();
        fsize = d.file_size;
        entry = d.entry_addr[31:0];
        if (d.entry_addr[63:32] != 0) flag(ST_BOUNDS, 0);
      end else if (!closed) begin
        pos = hdr_pos;
        if (hdr_pos < MaxHeaders) hdr_pos++;
        if (status == ST_OK && d.seg_type == 1 && d.seg_mem_bytes != 0) begin
          code = (pos >= MaxHeaders) ? ST_UNSUP : check_seg(d, b, e);
          if (code != ST_OK) flag(code, pos);
          else begin
            pg_base[n_seg] = b[31:PageBits];
            pg_end[n_seg] = e[32:PageBits];
            va_start[n_seg] = d.seg_vaddr[31:0];
            va_end[n_seg] = d.seg_vaddr[32:0] + d.seg_mem_bytes[32:0];
            n_seg++;
            if (low_mark == 0 || b < 33'(low_mark)) low_mark = b[31:0];
            if (e > high_mark) high_mark = e;
            if (e > brk) brk = e;
            r.seg_map_base = b[31:0];
            r.seg_pages = 21'((e - b) >> PageBits);
          end
        end else if (status == ST_OK && pos >= MaxHeaders) flag(ST_UNSUP, pos);
        if (d.last_header) begin
          if (status == ST_OK) begin
            hit = 0;
            for (int i = 0; i < n_seg; i++)
              if (33'(entry) >= 33'(va_start[i]) && 33'(entry) < va_end[i]) hit = 1;
            if (n_seg == 0) flag(ST_UNSUP, pos);
            else if (!hit) flag(ST_FORMAT, pos);
            else if (brk > 33'(stack_limit)) flag(ST_BOUNDS, pos);
          end
          closed = 1;
          r.final_result = 1;
        end
      end
      r.status = status;
      r.error_index = (err_pos > 15) ? 4'd15 : 4'(err_pos);
      r.seg_count = 4'(n_seg);
      r.img_low = low_mark;
      r.img_high = high_mark;
      r.brk_end = brk;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t a);
      out_item_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, a);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (a !== x) begin
        $display("%0t: mismatch expected %p actual %p", $time, x, a);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, cfg_we = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic [1:0] cfg_index = CFG_WIN_BASE;
  logic [32:0] cfg_data = '0;
  header_scoreboard sb = new();
  int stall_mode = 0;

  elf_load_segment_checker i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(3) == 0);
      default: out_stall <= ($urandom_range(9) < 6);
    endcase
    if ($urandom_range(60) == 0) stall_mode <= $urandom_range(2);
  end

  task automatic send_item(in_item_t d);
    in_valid <= 1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [32:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [63:0] r64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t start_item(logic [31:0] fs, logic [63:0] ep);
    in_item_t d;
    d = '0;
    d.req_type = REQ_START;
    d.file_size = fs;
    d.entry_addr = ep;
    return d;
  endfunction

  function automatic in_item_t hdr(logic [31:0] t, logic [63:0] off, logic [63:0] va,
                                   logic [63:0] fb, logic [63:0] mb, logic last);
    in_item_t d;
    d = '0;
    d.req_type = REQ_HEADER;
    d.seg_type = t;
    d.seg_offset = off;
    d.seg_vaddr = va;
    d.seg_file_bytes = fb;
    d.seg_mem_bytes = mb;
    d.last_header = last;
    return d;
  endfunction

  function automatic in_item_t noise();
    in_item_t d;
    d = '0;
    d.req_type = 1'($urandom_range(1));
    d.file_size = $urandom;
    d.entry_addr = r64();
    d.seg_type = $urandom;
    d.seg_offset = r64();
    d.seg_vaddr = r64();
    d.seg_file_bytes = r64();
    d.seg_mem_bytes = r64();
    d.last_header = 1'($urandom_range(1));
    return d;
  endfunction

  task automatic send_image();
    int nh;
    logic [31:0] va, mb, fb, ent, fs;
    in_item_t d;
    nh = ($urandom_range(20) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 9);
    fs = $urandom_range(20) == 0 ? $urandom : $urandom_range(200000);
    va = sb.win_base + $urandom_range(8) * 4096 + $urandom_range(4095);
    ent = va + $urandom_range(3000);
    if ($urandom_range(10) == 0) ent = $urandom;
    send_item(start_item(fs, ($urandom_range(30) == 0) ? r64() : {32'd0, ent}));
    for (int h = 0; h < nh; h++) begin
      mb = $urandom_range(1, 40000);
      fb = $urandom_range(mb);
      d = hdr(($urandom_range(8) == 0) ? $urandom_range(6) : 1,
              $urandom_range(fs > 60000 ? 60000 : fs), va, fb, mb, h == nh - 1);
      if ($urandom_range(12) == 0) d = noise();
      d.req_type = REQ_HEADER;
      d.last_header = (h == nh - 1);
      send_item(d);
      va = va + mb + ($urandom_range(3) == 0 ? 0 : $urandom_range(20000)) - $urandom_range(100);
    end
    if ($urandom_range(6) == 0) send_item(noise());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_item(hdr(1, 0, 64'h400000, 0, 16, 1));
    send_item(start_item(32'hFFFFFFFF, 64'h400010));
    send_item(hdr(1, 0, 64'h400000, 64'h100, 64'h2000, 0));
    send_item(hdr(2, 0, 0, 0, 0, 0));
    send_item(hdr(1, 64'h10, 64'h401800, 64'h10, 64'h10, 0));
    send_item(hdr(1, 0, 64'h500000, 64'h20, 64'h10, 1));
    send_item(hdr(1, 0, 64'h600000, 0, 64'h10, 1));
    send_item(start_item(0, 64'hFFFFFFFFFFFFFFFF));
    send_item(hdr(1, 0, 64'h400000, 0, 64'h10, 1));
    send_item(start_item(32'h1000, 64'h400000));
    send_item(hdr(1, 64'hFFFFFFFFFFFFFFFF, 64'h400000, 0, 64'h10, 0));
    send_item(start_item(32'h1000, 64'h400000));
    for (int i = 0; i < 17; i++) send_item(hdr(0, 0, 0, 0, 0, i == 16));
    send_item(start_item(32'hFFFFFFFF, 64'hFFFFF000));
    send_item(hdr(1, 0, 64'hFFFFF000, 0, 64'hFFF, 1));
    drain();
    write_reg(CFG_WIN_BASE, 33'd0);
    write_reg(CFG_WIN_LIMIT, 33'h100000000);
    write_reg(CFG_STACK_FLOOR, 33'hFFFFFFFF);
    write_reg(2'd3, 33'h1FFFFFFFF);
    send_item(start_item(32'hFFFFFFFF, 64'hFFFFF800));
    send_item(hdr(1, 0, 64'hFFFFF000, 0, 64'h1000, 1));
    send_item(start_item(32'h1000, 64'h0));
    send_item(hdr(1, 0, 0, 0, 64'h10, 1));
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_WIN_BASE, 33'd4194304);
          write_reg(CFG_WIN_LIMIT, 33'd3221225472);
          write_reg(CFG_STACK_FLOOR, 33'd3204448256);
        end
        1: begin
          write_reg(CFG_WIN_BASE, 33'hFFFFFFFF);
          write_reg(CFG_WIN_LIMIT, 33'd0);
          write_reg(CFG_STACK_FLOOR, 33'd0);
        end
        2: begin
          write_reg(CFG_WIN_BASE, 33'h10000);
          write_reg(CFG_WIN_LIMIT, 33'h480000);
          write_reg(CFG_STACK_FLOOR, 33'h440000);
        end
        default: begin
          write_reg(CFG_WIN_BASE, $urandom_range(32'h800000));
          write_reg(CFG_WIN_LIMIT, {1'b0, $urandom} | 33'h80000000);
          write_reg(CFG_STACK_FLOOR, {1'b0, $urandom});
        end
      endcase
      for (int k = 0; k < (ph == 1 ? 10 : 25); k++) send_image();
    end
    drain();
    if (sb.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end
endmodule
